@@ hdl/fbpa_pkg.sv @@
package fbpa_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 16;
	localparam int PROD_W     = IDX_W + SIZE_W;
	localparam int DIGIT_W    = 8;
	localparam int NUM_DIGITS = MAX_BLOCKS / DIGIT_W;
	localparam int DSEL_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int POS_W      = $clog2(DIGIT_W);
	localparam int STEP_W     = $clog2(ADDR_W);

	localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_BLOCKS);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] CFG_BASE  = 2'd0;
	localparam logic [1:0] CFG_SIZE  = 2'd1;
	localparam logic [1:0] CFG_COUNT = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(4);

	typedef struct packed {
		logic             done;
		logic             found;
		logic [IDX_W-1:0] index;
	} scan_res_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] quotient;
	} div_res_t;

endpackage

@@ hdl/fbpa_divider.sv @@
module fbpa_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
	input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
	output fbpa_pkg::div_res_t         res
);
	import fbpa_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] div_q;
	logic [ADDR_W-1:0] quo_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   diff;
	logic              ge;

	assign trial = {rem_q, quo_q[ADDR_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(ADDR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
			quo_q <= {quo_q[ADDR_W-2:0], ge};
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

@@ hdl/fbpa_scanner.sv @@
module fbpa_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fbpa_pkg::MAX_BLOCKS-1:0] used_map,
	input  logic [fbpa_pkg::CNT_W-1:0]    count,
	output fbpa_pkg::scan_res_t           res
);
	import fbpa_pkg::*;

	logic              busy_q;
	logic [DSEL_W-1:0] digit_q;
	logic [DIGIT_W-1:0] window;
	logic              hit;
	logic [POS_W-1:0]  pos;
	logic [CNT_W-1:0]  slot;
	logic              last;

	assign window = used_map[digit_q * DIGIT_W +: DIGIT_W];
	assign last   = (digit_q == DSEL_W'(NUM_DIGITS - 1));

	always_comb begin
		hit  = 1'b0;
		pos  = '0;
		slot = '0;
		for (int k = DIGIT_W - 1; k >= 0; k--) begin
			slot = CNT_W'(digit_q) * CNT_W'(DIGIT_W) + CNT_W'(k);
			if (!window[k] && slot < count) begin
				hit = 1'b1;
				pos = POS_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			digit_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			digit_q <= '0;
		end else if (busy_q) begin
			if (hit || last) begin
				busy_q <= 1'b0;
			end else begin
				digit_q <= digit_q + 1'b1;
			end
		end
	end

	assign res.done  = busy_q && (hit || last);
	assign res.found = hit;
	assign res.index = IDX_W'(CNT_W'(digit_q) * CNT_W'(DIGIT_W) + CNT_W'(pos));

endmodule

@@ hdl/fixed_block_pool_allocator_core.sv @@
// Fixed-size block allocator with one used bit per block, all free after reset.
// An allocate word is accepted while idle; the used bits are then scanned eight
// blocks per cycle, a multiply step scales the found index by the block size and
// a result step registers it. A free word runs its offset from the base through
// a bit-serial 32-bit divider, one quotient bit per cycle; a free below the base
// skips it. One word is processed at a time; the result register lets a new
// word be accepted while the previous result is still waiting on the output.
// Configuration writes are always taken and must only be issued while idle.
module fixed_block_pool_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [fbpa_pkg::ADDR_W-1:0]   free_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [fbpa_pkg::ADDR_W-1:0]   block_address,
	output logic [fbpa_pkg::IDX_W-1:0]    block_index
);
	import fbpa_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_MULT = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  count_q;
	logic [MAX_BLOCKS-1:0] used_q;
	logic              mode_q;
	logic [1:0]        stat_q;
	logic [IDX_W-1:0]  idx_q;
	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0]  count_eff;
	logic [SIZE_W-1:0] size_eff;
	logic              accept;
	logic              below;
	logic [ADDR_W-1:0] offset;
	logic              out_free;
	logic              idx_over;
	scan_res_t         scan_res;
	div_res_t          div_res;

	assign count_eff = (count_q > MAX_COUNT) ? MAX_COUNT : count_q;
	assign size_eff  = (size_q == '0) ? SIZE_W'(1) : size_q;
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign below     = free_address < base_q;
	assign offset    = free_address - base_q;
	assign out_free  = !out_valid || out_ready;
	assign idx_over  = (|div_res.quotient[ADDR_W-1:CNT_W]) ||
		(div_res.quotient[CNT_W-1:0] >= count_eff);

	fbpa_scanner u_scanner (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && !mode),
		.used_map (used_q),
		.count    (count_eff),
		.res      (scan_res)
	);

	fbpa_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && mode && !below),
		.dividend (offset),
		.divisor  (size_eff),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			size_q  <= SIZE_RESET;
			count_q <= MAX_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data;
				CFG_SIZE:  size_q  <= cfg_data[SIZE_W-1:0];
				CFG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= !mode ? S_SCAN : (below ? S_FIN : S_DIV);
					end
				end
				S_SCAN: begin
					if (scan_res.done) begin
						state_q <= scan_res.found ? S_MULT : S_FIN;
					end
				end
				S_MULT: state_q <= S_FIN;
				S_DIV: begin
					if (div_res.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q   <= S_IDLE;
						out_valid <= 1'b1;
						if (stat_q == ST_OK) begin
							used_q[idx_q] <= !mode_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			stat_q <= (mode && below) ? ST_RANGE : ST_OK;
			idx_q  <= '0;
			prod_q <= '0;
		end
		if (state_q == S_SCAN && scan_res.done) begin
			stat_q <= scan_res.found ? ST_OK : ST_FULL;
			idx_q  <= scan_res.found ? scan_res.index : '0;
		end
		if (state_q == S_MULT) begin
			prod_q <= PROD_W'(idx_q) * PROD_W'(size_eff);
		end
		if (state_q == S_DIV && div_res.done) begin
			stat_q <= idx_over ? ST_RANGE : ST_OK;
			idx_q  <= idx_over ? '0 : div_res.quotient[IDX_W-1:0];
		end
		if (state_q == S_FIN && out_free) begin
			status        <= stat_q;
			block_index   <= idx_q;
			block_address <= (!mode_q && stat_q == ST_OK) ?
				base_q + ADDR_W'(prod_q) : '0;
		end
	end

endmodule
